>>> hw/rtl/wtr_pkg.sv
`timescale 1ns / 1ps

package wtr_pkg;

    // ring sizing
    localparam int PKG_RING_SLOTS = 32;
    localparam int REC_CAP        = 32;

    // divider sizes: quotient, dividend and divisor widths
    localparam int QW    = 15;
    localparam int DVD_W = 24;
    localparam int DSR_W = 13;

    // configuration register indexes
    localparam logic [2:0] CFG_LENGTH = 3'd0;
    localparam logic [2:0] CFG_SAMPLE = 3'd1;
    localparam logic [2:0] CFG_FADE   = 3'd2;
    localparam logic [2:0] CFG_RED    = 3'd3;
    localparam logic [2:0] CFG_GREEN  = 3'd4;
    localparam logic [2:0] CFG_BLUE   = 3'd5;
    localparam logic [2:0] CFG_ALPHA  = 3'd6;

    // configuration reset values
    localparam logic [5:0] RST_LENGTH = 6'd20;
    localparam logic [5:0] RST_SAMPLE = 6'd2;
    localparam logic [5:0] RST_FADE   = 6'd3;
    localparam logic [7:0] RST_RED    = 8'd255;
    localparam logic [7:0] RST_GREEN  = 8'd170;
    localparam logic [7:0] RST_BLUE   = 8'd0;
    localparam logic [7:0] RST_ALPHA  = 8'd128;

    // per-record division sequence
    localparam logic [2:0] OP_WIDTH  = 3'd0;
    localparam logic [2:0] OP_HEIGHT = 3'd1;
    localparam logic [2:0] OP_RED    = 3'd2;
    localparam logic [2:0] OP_GREEN  = 3'd3;
    localparam logic [2:0] OP_BLUE   = 3'd4;
    localparam logic [2:0] OP_ALPHA  = 3'd5;

    // window geometry as stored in the ring
    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [14:0]        w;
        logic [14:0]        h;
    } t_geom;

    // request to the shared divider
    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DSR_W-1:0] divisor;
    } t_div_req;

endpackage

>>> hw/rtl/wtr_div.sv
`timescale 1ns / 1ps

module wtr_div
    import wtr_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_div_req      i_req,
    output logic          o_done,
    output logic [QW-1:0] o_quot
);

    localparam int CNT_W = $clog2(QW);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DSR_W-1:0] r_rem;
    logic [DSR_W-1:0] r_dsr;
    logic [QW-1:0]    r_q;

    logic [DSR_W:0]   w_trial;
    logic [DSR_W:0]   w_diff;
    logic             w_ge;

    // one restoring step: shift in the next dividend bit and try the subtract
    always_comb begin
        w_trial = {r_rem, r_q[QW-1]};
        w_diff  = w_trial - {1'b0, r_dsr};
        w_ge    = (w_trial >= {1'b0, r_dsr});
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(QW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: upper dividend bits seed the remainder, lower bits become quotient
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= DSR_W'(i_req.dividend[DVD_W-1:QW]);
            r_q   <= i_req.dividend[QW-1:0];
            r_dsr <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DSR_W-1:0] : w_trial[DSR_W-1:0];
            r_q   <= {r_q[QW-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

>>> hw/rtl/window_trail_ring_renderer.sv
`timescale 1ns / 1ps

// Window trail ring renderer. Each input transfer is one display tick with the
// window geometry; the block keeps a ring of past geometries in a synchronous
// memory with a registered read and, whenever the trail changes, sends one
// record per trail slot (N records, N the effective trail length, the last
// one with tlast). A tick is accepted only while the block is idle; a tick
// that emits then occupies the block until all its records are out. A hidden
// record skips the divisions; a drawn one runs its six divisions (width,
// height, three colors, alpha) one after another through a single shared
// 15-step restoring divider.
// Output records sit in a register, so a stalled consumer only pauses the block.
// Configuration should be written only while no tick is in flight; writing the
// length clears the trail.
module window_trail_ring_renderer
    import wtr_pkg::*;
#(
    parameter int RING_SLOTS = PKG_RING_SLOTS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // input tick: win_x[15:0], win_y[31:16], win_width[46:32], win_height[61:47]
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [63:0]  i_s_tdata,
    // record: slot[4:0], rect_x[21:5], rect_y[38:22], rect_width[53:39],
    // rect_height[68:54], out_red[76:69], out_green[84:77], out_blue[92:85],
    // out_alpha[100:93]
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [103:0] o_m_tdata,
    // record flags: shown[0]
    output logic         o_m_tuser,
    output logic         o_m_tlast,
    // configuration
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_idx,
    input  logic [7:0]   i_cfg_data
);

    localparam int NCAP = (RING_SLOTS < REC_CAP) ? RING_SLOTS : REC_CAP;
    localparam int AW   = $clog2(NCAP);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_SLOT   = 7'b0000010,
        S_CHK    = 7'b0000100,
        S_DLOAD  = 7'b0001000,
        S_DSTART = 7'b0010000,
        S_DWAIT  = 7'b0100000,
        S_OUT    = 7'b1000000
    } t_state;

    // configuration registers
    logic [5:0] r_length, r_sample, r_fade;
    logic [7:0] r_red, r_green, r_blue, r_alpha;

    // trail state
    t_geom            r_prev, n_prev;
    logic             r_primed, n_primed;
    logic             r_moving, n_moving;
    logic [5:0]       r_tc, n_tc;
    logic [AW-1:0]    r_head, n_head;
    logic [5:0]       r_pc, n_pc;
    logic [NCAP-1:0]  r_valid, n_valid;

    // ring memory
    t_geom            r_ring [NCAP];
    t_geom            r_rd;
    logic             w_mem_we;
    logic [AW-1:0]    w_mem_wa;
    t_geom            w_mem_wd;

    // emission control
    t_state           r_state, n_state;
    logic [4:0]       r_slot;
    logic [13:0]      r_p;
    logic             r_hide;
    logic [2:0]       r_op;
    logic [14:0]      r_rw, r_rh;
    logic [7:0]       r_cr, r_cg, r_cb, r_ca;
    logic             r_dstart;
    logic [DVD_W-1:0] r_dvd;
    logic [DSR_W-1:0] r_dsr;
    t_div_req         w_dreq;

    // output register
    logic             r_m_valid;
    logic [103:0]     r_m_data;
    logic             r_m_user;
    logic             r_m_last;

    // combinational helpers
    t_geom            w_cur;
    logic [5:0]       w_n;
    logic             w_accept;
    logic             w_emit;
    logic [5:0]       w_tc1;
    logic [5:0]       w_head6;
    logic [5:0]       w_nh6;
    logic [AW-1:0]    w_push_head;
    logic [5:0]       w_cnt;
    logic [6:0]       w_old7;
    logic [6:0]       w_old_mod;
    logic [5:0]       w_idx6;
    logic [AW-1:0]    w_idx;
    logic [5:0]       w_age;
    logic [8:0]       w_num;
    logic [12:0]      w_den10;
    logic [12:0]      w_cden;
    logic [21:0]      w_faint_lhs;
    logic             w_hidden;
    logic [14:0]      w_mul_a;
    logic [13:0]      w_mul_b;
    logic [28:0]      w_prod;
    logic             w_out_free;
    logic             w_last_slot;
    logic [16:0]      w_rx, w_ry;
    logic [14:0]      w_wdiff, w_hdiff;
    logic             w_div_done;
    logic [QW-1:0]    w_quot;

    assign w_cur.x = i_s_tdata[15:0];
    assign w_cur.y = i_s_tdata[31:16];
    assign w_cur.w = i_s_tdata[46:32];
    assign w_cur.h = i_s_tdata[61:47];

    assign w_accept   = i_s_tvalid && o_s_tready;
    assign o_s_tready = (r_state == S_IDLE);

    // effective trail length
    always_comb begin
        if (r_length < 6'd2) begin
            w_n = 6'd2;
        end else if (r_length > 6'(NCAP)) begin
            w_n = 6'(NCAP);
        end else begin
            w_n = r_length;
        end
    end

    // ring index helpers
    always_comb begin
        w_head6     = 6'(r_head);
        w_nh6       = w_head6 + 6'd1;
        w_push_head = (w_nh6 >= w_n) ? '0 : w_nh6[AW-1:0];
        w_tc1       = r_tc + 6'd1;
        w_cnt       = (r_pc > w_n) ? w_n : r_pc;
        w_old7      = 7'(w_head6) + 7'(w_n) + 7'd1 - 7'(w_cnt);
        w_old_mod   = (w_old7 >= 7'(w_n)) ? (w_old7 - 7'(w_n)) : w_old7;
        if (w_head6 >= 6'(r_slot)) begin
            w_idx6 = w_head6 - 6'(r_slot);
        end else begin
            w_idx6 = w_head6 + w_n - 6'(r_slot);
        end
        w_idx = w_idx6[AW-1:0];
    end

    // tick update: decide push, drop and emission
    always_comb begin
        n_prev   = r_prev;
        n_primed = r_primed;
        n_moving = r_moving;
        n_tc     = r_tc;
        n_head   = r_head;
        n_pc     = r_pc;
        n_valid  = r_valid;
        w_mem_we = 1'b0;
        w_mem_wa = w_push_head;
        w_mem_wd = r_prev;
        w_emit   = 1'b0;
        if (w_accept) begin
            if (!r_primed) begin
                n_prev   = w_cur;
                n_primed = 1'b1;
            end else if (w_cur != r_prev) begin
                n_moving = 1'b1;
                n_tc     = w_tc1;
                if (w_tc1 >= r_sample) begin
                    w_mem_we = 1'b1;
                    w_mem_wd = r_prev;
                    n_head   = w_push_head;
                    n_valid[w_push_head] = 1'b1;
                    n_pc     = (r_pc < w_n) ? r_pc + 6'd1 : r_pc;
                    n_tc     = '0;
                end
                n_prev = w_cur;
                w_emit = 1'b1;
            end else if (r_moving) begin
                w_mem_we = 1'b1;
                w_mem_wd = w_cur;
                n_head   = w_push_head;
                n_valid[w_push_head] = 1'b1;
                n_pc     = (r_pc < w_n) ? r_pc + 6'd1 : r_pc;
                n_moving = 1'b0;
                n_tc     = '0;
                w_emit   = 1'b1;
            end else if (r_pc != 6'd0) begin
                n_tc = w_tc1;
                if (w_tc1 >= r_fade) begin
                    n_valid[w_old_mod[AW-1:0]] = 1'b0;
                    n_pc   = w_cnt - 6'd1;
                    n_tc   = '0;
                    w_emit = 1'b1;
                end
            end
        end
        // length write clears the trail
        if (i_cfg_we && i_cfg_idx == CFG_LENGTH) begin
            n_valid  = '0;
            n_head   = '0;
            n_pc     = '0;
            n_tc     = '0;
            n_moving = 1'b0;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_length <= RST_LENGTH;
            r_sample <= RST_SAMPLE;
            r_fade   <= RST_FADE;
            r_red    <= RST_RED;
            r_green  <= RST_GREEN;
            r_blue   <= RST_BLUE;
            r_alpha  <= RST_ALPHA;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LENGTH: r_length <= i_cfg_data[5:0];
                CFG_SAMPLE: r_sample <= i_cfg_data[5:0];
                CFG_FADE:   r_fade   <= i_cfg_data[5:0];
                CFG_RED:    r_red    <= i_cfg_data;
                CFG_GREEN:  r_green  <= i_cfg_data;
                CFG_BLUE:   r_blue   <= i_cfg_data;
                CFG_ALPHA:  r_alpha  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // trail state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev   <= '0;
            r_primed <= 1'b0;
            r_moving <= 1'b0;
            r_tc     <= '0;
            r_head   <= '0;
            r_pc     <= '0;
            r_valid  <= '0;
        end else begin
            r_prev   <= n_prev;
            r_primed <= n_primed;
            r_moving <= n_moving;
            r_tc     <= n_tc;
            r_head   <= n_head;
            r_pc     <= n_pc;
            r_valid  <= n_valid;
        end
    end

    // ring memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_ring[w_mem_wa] <= w_mem_wd;
        end
        r_rd <= r_ring[w_idx];
    end

    // per-slot arithmetic
    always_comb begin
        w_age       = w_n - 6'(r_slot);
        w_num       = 9'(w_n) * 9'd10 - 9'(r_slot) * 9'd7;
        w_den10     = 13'(w_n) * 13'd10;
        w_cden      = 13'(w_n) * 13'd255;
        w_faint_lhs = 22'(r_p) * 22'd200;
        w_hidden    = (r_slot == 5'd0) || (6'(r_slot) >= r_pc) || !r_valid[w_idx]
                      || (w_faint_lhs < 22'(w_cden));
        case (r_op)
            OP_WIDTH: begin
                w_mul_a = r_rd.w;
                w_mul_b = 14'(w_num);
            end
            OP_HEIGHT: begin
                w_mul_a = r_rd.h;
                w_mul_b = 14'(w_num);
            end
            OP_RED: begin
                w_mul_a = 15'(r_red);
                w_mul_b = r_p;
            end
            OP_GREEN: begin
                w_mul_a = 15'(r_green);
                w_mul_b = r_p;
            end
            OP_BLUE: begin
                w_mul_a = 15'(r_blue);
                w_mul_b = r_p;
            end
            default: begin
                w_mul_a = 15'd255;
                w_mul_b = r_p;
            end
        endcase
        w_prod = 29'(w_mul_a) * 29'(w_mul_b);
    end

    // centred rectangle
    always_comb begin
        w_wdiff = r_rd.w - r_rw;
        w_hdiff = r_rd.h - r_rh;
        w_rx    = {r_rd.x[15], r_rd.x} + 17'(w_wdiff[14:1]);
        w_ry    = {r_rd.y[15], r_rd.y} + 17'(w_hdiff[14:1]);
    end

    assign w_out_free  = !r_m_valid || i_m_tready;
    assign w_last_slot = (6'(r_slot) == w_n - 6'd1);

    // record sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_emit) begin
                    n_state = S_SLOT;
                end
            end
            S_SLOT:   n_state = S_CHK;
            S_CHK:    n_state = w_hidden ? S_OUT : S_DLOAD;
            S_DLOAD:  n_state = S_DSTART;
            S_DSTART: n_state = S_DWAIT;
            S_DWAIT: begin
                if (w_div_done) begin
                    n_state = (r_op == OP_ALPHA) ? S_OUT : S_DLOAD;
                end
            end
            S_OUT: begin
                if (w_out_free) begin
                    n_state = w_last_slot ? S_IDLE : S_SLOT;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_dstart <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_dstart <= (r_state == S_DLOAD);
        end
    end

    // slot datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_slot <= '0;
            end
            S_SLOT: begin
                r_p <= 14'(r_alpha) * 14'(w_age);
            end
            S_CHK: begin
                r_hide <= w_hidden;
                r_op   <= OP_WIDTH;
            end
            S_DLOAD: begin
                r_dvd <= w_prod[DVD_W-1:0];
                r_dsr <= (r_op == OP_WIDTH || r_op == OP_HEIGHT) ? w_den10 : w_cden;
            end
            S_DWAIT: begin
                if (w_div_done) begin
                    case (r_op)
                        OP_WIDTH:  r_rw <= w_quot;
                        OP_HEIGHT: r_rh <= w_quot;
                        OP_RED:    r_cr <= w_quot[7:0];
                        OP_GREEN:  r_cg <= w_quot[7:0];
                        OP_BLUE:   r_cb <= w_quot[7:0];
                        default:   r_ca <= w_quot[7:0];
                    endcase
                    r_op <= r_op + 3'd1;
                end
            end
            S_OUT: begin
                if (w_out_free) begin
                    r_slot <= r_slot + 5'd1;
                end
            end
            default: begin
            end
        endcase
    end

    // divider request
    assign w_dreq.start    = r_dstart;
    assign w_dreq.dividend = r_dvd;
    assign w_dreq.divisor  = r_dsr;

    // shared divider
    wtr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_dreq),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (r_state == S_OUT && w_out_free) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && w_out_free) begin
            r_m_last <= w_last_slot;
            r_m_user <= !r_hide;
            if (r_hide) begin
                r_m_data <= {99'd0, r_slot};
            end else begin
                r_m_data <= {3'd0, r_ca, r_cb, r_cg, r_cr, r_rh, r_rw, w_ry, w_rx, r_slot};
            end
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tuser  = r_m_user;
    assign o_m_tlast  = r_m_last;

    // point count never exceeds the trail length
    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_pc <= w_n)
        else $error("point count above trail length");

    // head stays inside the used part of the ring
    assert property (@(posedge i_clk) disable iff (!i_rst_n) 6'(r_head) < w_n)
        else $error("head outside trail");

    // the final record of a tick carries the highest slot
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tlast) |-> (6'(o_m_tdata[4:0]) == w_n - 6'd1))
        else $error("tlast on wrong slot");

    // divider results only arrive while the sequencer waits for them
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DWAIT))
        else $error("unexpected divider result");

    // a tapered rectangle is never wider than its window
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && !r_hide) |-> (r_rw <= r_rd.w && r_rh <= r_rd.h))
        else $error("rectangle grew");

endmodule

>>> tb/sv/wtr_trail_checker.sv
`timescale 1ns / 1ps

module wtr_trail_checker
    import wtr_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    // win_x, win_y, win_width, win_height from the lowest bit up
    input  logic [63:0]  i_s_tdata,
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    // slot, rect_x, rect_y, rect_width, rect_height, red, green, blue, alpha
    input  logic [103:0] i_m_tdata,
    // shown
    input  logic         i_m_tuser,
    input  logic         i_m_tlast,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_idx,
    input  logic [7:0]   i_cfg_data,
    output int           o_failures,
    output int           o_pending
);

    typedef struct {
        logic [4:0]         slot;
        logic               shown;
        logic [16:0]        rx;
        logic [16:0]        ry;
        logic [14:0]        rw;
        logic [14:0]        rh;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic [7:0]         alpha;
        logic               last;
    } t_record;

    t_record    record_q[$];

    // mirrored configuration
    logic [5:0] len_r, sample_r, fade_r;
    logic [7:0] red_r, green_r, blue_r, alpha_r;

    // mirrored trail state
    t_geom      prev_g;
    bit         primed, moving;
    int         tick_cnt, head, npoints;
    t_geom      ring_g [PKG_RING_SLOTS];
    bit         ring_v [PKG_RING_SLOTS];

    function automatic int trail_slots();
        int n;
        n = len_r;
        if (n < 2) n = 2;
        if (n > PKG_RING_SLOTS) n = PKG_RING_SLOTS;
        return n;
    endfunction

    function automatic void clear_trail();
        for (int k = 0; k < PKG_RING_SLOTS; k++) ring_v[k] = 0;
        head = 0;
        npoints = 0;
        tick_cnt = 0;
        moving = 0;
    endfunction

    function automatic void push_point(t_geom g, int n);
        head = (head + 1) % n;
        ring_g[head] = g;
        ring_v[head] = 1;
        if (npoints < n) npoints++;
    endfunction

    // one record per slot, newest first
    function automatic void emit_records(int n);
        t_record r;
        int idx;
        longint unsigned a, age, num, den, cden, rw, rh;
        t_geom g;
        a = alpha_r;
        for (int i = 0; i < n; i++) begin
            r = '{default: '0};
            r.slot = i[4:0];
            r.last = (i == n - 1);
            idx = (head + n - i) % n;
            age = n - i;
            if (!(i == 0 || i >= npoints || !ring_v[idx]) && !(200 * a * age < 255 * n)) begin
                g = ring_g[idx];
                num = 10 * n - 7 * i;
                den = 10 * n;
                cden = 255 * n;
                rw = (longint'(g.w) * num) / den;
                rh = (longint'(g.h) * num) / den;
                r.shown = 1;
                r.rw = rw[14:0];
                r.rh = rh[14:0];
                r.rx = 17'(int'(g.x) + int'((longint'(g.w) - rw) / 2));
                r.ry = 17'(int'(g.y) + int'((longint'(g.h) - rh) / 2));
                r.red = 8'((red_r * a * age) / cden);
                r.green = 8'((green_r * a * age) / cden);
                r.blue = 8'((blue_r * a * age) / cden);
                r.alpha = 8'((a * age) / n);
            end
            record_q.push_back(r);
        end
    endfunction

    // predict the records caused by one tick
    function automatic void predict_tick(t_geom cur);
        int n, lim, oldest;
        n = trail_slots();
        if (!primed) begin
            prev_g = cur;
            primed = 1;
        end else if (cur != prev_g) begin
            moving = 1;
            tick_cnt = (tick_cnt + 1) & 63;
            if (tick_cnt >= sample_r) begin
                push_point(prev_g, n);
                tick_cnt = 0;
            end
            prev_g = cur;
            emit_records(n);
        end else if (moving) begin
            push_point(cur, n);
            moving = 0;
            tick_cnt = 0;
            emit_records(n);
        end else if (npoints > 0) begin
            tick_cnt = (tick_cnt + 1) & 63;
            if (tick_cnt >= fade_r) begin
                lim = (npoints > n) ? n : npoints;
                oldest = (head + n + 1 - lim) % n;
                ring_v[oldest] = 0;
                npoints = lim - 1;
                tick_cnt = 0;
                emit_records(n);
            end
        end
    endfunction

    function automatic void check_field(string name, longint unsigned exp_v,
                                        longint unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            o_failures++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_record e;
        t_geom   g;
        if (!i_rst_n) begin
            len_r = RST_LENGTH;
            sample_r = RST_SAMPLE;
            fade_r = RST_FADE;
            red_r = RST_RED;
            green_r = RST_GREEN;
            blue_r = RST_BLUE;
            alpha_r = RST_ALPHA;
            prev_g = '0;
            primed = 0;
            for (int k = 0; k < PKG_RING_SLOTS; k++) ring_g[k] = '0;
            clear_trail();
            record_q.delete();
        end else begin
            // compare a record transfer against the oldest expectation
            if (i_m_tvalid && i_m_tready) begin
                if (record_q.size() == 0) begin
                    $error("record transfer with no expected record, slot %0d",
                           i_m_tdata[4:0]);
                    o_failures++;
                end else begin
                    e = record_q.pop_front();
                    check_field("slot", e.slot, i_m_tdata[4:0]);
                    check_field("shown", e.shown, i_m_tuser);
                    check_field("rect_x", e.rx, i_m_tdata[21:5]);
                    check_field("rect_y", e.ry, i_m_tdata[38:22]);
                    check_field("rect_width", e.rw, i_m_tdata[53:39]);
                    check_field("rect_height", e.rh, i_m_tdata[68:54]);
                    check_field("out_red", e.red, i_m_tdata[76:69]);
                    check_field("out_green", e.green, i_m_tdata[84:77]);
                    check_field("out_blue", e.blue, i_m_tdata[92:85]);
                    check_field("out_alpha", e.alpha, i_m_tdata[100:93]);
                    check_field("last", e.last, i_m_tlast);
                end
            end
            // register writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_LENGTH: begin
                        len_r = i_cfg_data[5:0];
                        clear_trail();
                    end
                    CFG_SAMPLE: sample_r = i_cfg_data[5:0];
                    CFG_FADE:   fade_r = i_cfg_data[5:0];
                    CFG_RED:    red_r = i_cfg_data;
                    CFG_GREEN:  green_r = i_cfg_data;
                    CFG_BLUE:   blue_r = i_cfg_data;
                    CFG_ALPHA:  alpha_r = i_cfg_data;
                    default: ;
                endcase
            end
            // tick transfer
            if (i_s_tvalid && i_s_tready) begin
                g.x = i_s_tdata[15:0];
                g.y = i_s_tdata[31:16];
                g.w = i_s_tdata[46:32];
                g.h = i_s_tdata[61:47];
                predict_tick(g);
            end
        end
        o_pending = record_q.size();
    end

    initial o_failures = 0;

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import wtr_pkg::*;

    logic         i_clk = 0;
    logic         i_rst_n = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [63:0]  s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [103:0] m_tdata;
    logic         m_tuser;
    logic         m_tlast;
    logic         cfg_we = 0;
    logic [2:0]   cfg_idx = '0;
    logic [7:0]   cfg_data = '0;

    int           failures;
    int           pending;
    int           src_idle = 0;
    int           snk_stall = 0;
    bit           hold_req = 0;
    bit           hold_done = 0;
    int           hold_left = 0;
    t_geom        last_g = '0;

    always #5 i_clk = ~i_clk;

    window_trail_ring_renderer DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .o_m_tlast  (m_tlast),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    wtr_trail_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .i_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .i_m_tdata  (m_tdata),
        .i_m_tuser  (m_tuser),
        .i_m_tlast  (m_tlast),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .o_failures (failures),
        .o_pending  (pending)
    );

    // record receiver: random stalls plus one long hold-off
    always @(posedge i_clk) begin
        if (hold_req && !hold_done) begin
            hold_left = 600;
            hold_done = 1;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= snk_stall);
        end
    end

    // offer one tick and wait for its transfer
    task automatic send_tick(input t_geom g);
        if ($urandom_range(99) < src_idle) begin
            s_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < src_idle);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {2'b00, g.h, g.w, g.y, g.x};
        last_g = g;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic write_all(input int len, input int smp, input int fad, input int r,
                             input int g, input int b, input int a);
        int vals[7];
        vals = '{len, smp, fad, r, g, b, a};
        for (int k = 0; k < 7; k++) begin
            cfg_we <= 1'b1;
            cfg_idx <= 3'(k);
            cfg_data <= 8'(vals[k]);
            @(posedge i_clk);
        end
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // mostly still runs and small moves so the trail fills and fades
    function automatic t_geom next_geom(t_geom p);
        t_geom g;
        int r;
        g = p;
        r = $urandom_range(99);
        if (r < 45) begin
            g = p;
        end else if (r < 75) begin
            g.x = p.x + 16'($urandom_range(40)) - 16'd20;
            g.y = p.y + 16'($urandom_range(40)) - 16'd20;
        end else if (r < 85) begin
            g.w = 15'($urandom);
            g.h = 15'($urandom);
        end else begin
            g.x = 16'($urandom);
            g.y = 16'($urandom);
            g.w = 15'($urandom);
            g.h = 15'($urandom);
        end
        return g;
    endfunction

    initial begin
        t_geom dir_g[20];
        t_geom ga, gb, gc, gd, ge;
        int len, smp, fad, nitems;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // write beyond the register list is ignored
        cfg_we <= 1'b1;
        cfg_idx <= 3'd7;
        cfg_data <= 8'hff;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(posedge i_clk);

        // directed: priming tick, field extremes, stop, partial fade
        ga = '{x: -16'sd32768, y: 16'sd32767, w: 15'd0, h: 15'h7fff};
        gb = '{x: 16'sd32767, y: -16'sd32768, w: 15'h7fff, h: 15'd0};
        gc = '{x: 16'sd0, y: 16'sd0, w: 15'd1, h: 15'd1};
        gd = '{x: -16'sd1, y: -16'sd1, w: 15'h7fff, h: 15'h7fff};
        ge = '{x: 16'sd100, y: 16'sd200, w: 15'd640, h: 15'd480};
        dir_g = '{ga, gb, gc, gd, ga, gb, gd, ge, ge, ge, ge, ge, ge, ge, ge, ge,
                  ge, ge, ge, ge};
        foreach (dir_g[k]) send_tick(dir_g[k]);
        drain();

        // random phases over several register settings
        for (int ph = 1; ph <= 8; ph++) begin
            case (ph % 4)
                0: begin src_idle = 0;  snk_stall = 0;  end
                1: begin src_idle = 84; snk_stall = 0;  end
                2: begin src_idle = 0;  snk_stall = 84; end
                default: begin src_idle = 37; snk_stall = 37; end
            endcase
            nitems = 50;
            case (ph)
                1: write_all(4, 1, 1, 255, 255, 255, 255);
                2: write_all(2, 63, 63, 0, 0, 0, 0);
                3: write_all(0, 0, 0, $urandom_range(255), $urandom_range(255),
                             $urandom_range(255), 255);
                4: begin
                    write_all(63, 1, 2, 255, 0, 255, 255);
                    nitems = 30;
                end
                5: write_all(32, 3, 5, $urandom_range(255), $urandom_range(255),
                             $urandom_range(255), 1);
                default: begin
                    len = $urandom_range(3, 10);
                    smp = $urandom_range(1, 6);
                    fad = $urandom_range(1, 6);
                    write_all(len, smp, fad, $urandom_range(255), $urandom_range(255),
                              $urandom_range(255), $urandom_range(255));
                end
            endcase
            // long receiver hold-off while ticks keep coming
            if (ph == 7) hold_req = 1;
            for (int k = 0; k < nitems; k++) send_tick(next_geom(last_g));
            drain();
        end

        repeat (200) @(posedge i_clk);
        if (failures == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // run limit
    initial begin
        #100ms;
        $display("Some tests failed");
        $finish;
    end

endmodule
